/* src/jlsc_pkg.sv */
// Package for the jerk-limited speed cap: widths, register indexes,
// shared structs and the 32-bit saturation helper. No dependencies.
`timescale 1ns / 1ps
package jlsc_pkg;

  localparam int SPEED_W    = 20;
  localparam int DT_W       = 20;
  localparam int LIM_W      = 18;
  localparam int JERK_W     = 20;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // shared multiply/divide unit
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 22;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int QUO_W   = PROD_W - 1;
  localparam int DIV_D_W = DT_W;

  localparam logic [DT_W-1:0] MICRO = DT_W'(1000000);

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL_LIM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JERK_LIM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_ACCEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_DECEL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VEH_ACCEL   = 3'd6;

  localparam logic [LIM_W-1:0] VEH_ACCEL_RST = LIM_W'(4096);

  typedef struct packed {
    logic              enable;
    logic [LIM_W-1:0]  accel_lim;
    logic [LIM_W-1:0]  decel_lim;
    logic [JERK_W-1:0] jerk_lim;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_status_t;

  function automatic logic signed [ACC_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-ACC_W:0] top;
    top = v[PROD_W-1:ACC_W-1];
    if ((&top) || !(|top)) begin
      return v[ACC_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

endpackage

/* src/jerk_limited_speed_cap.sv */
// Jerk-limited speed cap, top level: sequencer, working registers, config, shared muldiv.
// Pass-through words (disabled, no profile, invalid profile): result valid in the cycle after accept.
// Otherwise 1 to 6 multiply-divide operations (55 quotient bits, one per cycle) run before the
// result is valid. One word at a time, not ready while busy or while the result waits. Reset
// (async, active low) clears the stored acceleration and sets config to defaults. Depends on
// jlsc_pkg, jlsc_cfg_regs, jlsc_muldiv.
`timescale 1ns / 1ps
module jerk_limited_speed_cap (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [jlsc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [jlsc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [jlsc_pkg::SPEED_W-1:0]   command_speed_i,
  input  logic signed [jlsc_pkg::SPEED_W-1:0]   previous_speed_i,
  input  logic        [jlsc_pkg::DT_W-1:0]      tick_length_i,
  input  logic                                 profile_present_i,
  input  logic                                 profile_valid_i,
  input  logic signed [jlsc_pkg::SPEED_W-1:0]   profile_speed_here_i,
  input  logic signed [jlsc_pkg::SPEED_W-1:0]   profile_speed_ahead_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [jlsc_pkg::SPEED_W-1:0]   capped_speed_o,
  output logic                                 applied_o,
  output logic                                 active_o,
  output logic signed [jlsc_pkg::SPEED_W-1:0]   profile_speed_used_o,
  output logic signed [jlsc_pkg::ACC_W-1:0]     implied_accel_o,
  output logic signed [jlsc_pkg::ACC_W-1:0]     jerk_rate_o,
  output logic                                 jerk_valid_o
);
  import jlsc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_MD   = 3'd3;
  localparam logic [2:0] S_LIM  = 3'd4;
  localparam logic [2:0] S_JRK  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  cfg_t       cfg;
  md_status_t md_st;

  logic [2:0] state_q, state_d;
  logic       issue_q, issue_d;
  logic       second_q, second_d;
  logic       applied_q, applied_d;
  logic       jv_q, jv_d;
  logic       have_last_q, have_last_d;
  logic signed [ACC_W-1:0]   last_q, last_d;

  logic signed [SPEED_W-1:0] cmd_q, cmd_d, prev_q, prev_d, prof_q, prof_d;
  logic signed [SPEED_W-1:0] target_q, target_d, capped_q, capped_d;
  logic [DT_W-1:0]           dt_q, dt_d;
  logic signed [ACC_W-1:0]   accel_q, accel_d, jerk_q, jerk_d;
  logic signed [MUL_A_W-1:0] lim_q, lim_d;

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic [DIV_D_W-1:0]        op_d;
  logic signed [PROD_W-1:0]  res;

  // input side
  logic signed [SPEED_W-1:0] prof_in, min_in, target_in, prev_in;
  logic [DT_W-1:0]           div_w;
  logic                      long_tick, jerk_on;

  // result side
  logic signed [21:0]        tgt22, prv22, step22, diff22, mn22;
  logic signed [MUL_A_W-1:0] md34, lo34, hi34, acc34, mnv34;
  logic signed [PROD_W-1:0]  x56, x0, prof56;
  logic signed [ACC_W-1:0]   sat_res;

  jlsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  jlsc_muldiv u_md (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (issue_q && state_q != S_IDLE && state_q != S_OUT),
    .a_i     (op_a),
    .b_i     (op_b),
    .d_i     (op_d),
    .status_o(md_st),
    .q_o     (res)
  );

  always_comb begin
    prof_in = profile_speed_here_i;
    if (profile_speed_here_i <= 0) begin
      prof_in = (profile_speed_ahead_i > profile_speed_here_i) ? profile_speed_ahead_i
                                                               : profile_speed_here_i;
    end
    min_in    = (command_speed_i < prof_in) ? command_speed_i : prof_in;
    target_in = (min_in < 0) ? '0 : min_in;
    prev_in   = (previous_speed_i < 0) ? '0 : previous_speed_i;
  end

  assign long_tick = dt_q > DT_W'(1);
  assign div_w     = long_tick ? dt_q : DT_W'(1);
  assign jerk_on   = (cfg.jerk_lim != '0) && have_last_q;

  // operand select for the shared unit
  always_comb begin
    op_a = '0;
    op_b = $signed(MUL_B_W'(MICRO));
    op_d = MICRO;
    case (state_q)
      S_STEP: begin
        op_a = (target_q >= prev_q) ? $signed(MUL_A_W'(cfg.accel_lim))
                                    : $signed(MUL_A_W'(cfg.decel_lim));
        op_b = $signed(MUL_B_W'(dt_q));
      end
      S_ACC: begin
        op_a = MUL_A_W'(capped_q) - MUL_A_W'(prev_q);
        op_d = div_w;
      end
      S_MD: begin
        op_a = $signed(MUL_A_W'(cfg.jerk_lim));
        op_b = $signed(MUL_B_W'(dt_q));
      end
      S_LIM: begin
        op_a = lim_q;
        op_b = $signed(MUL_B_W'(dt_q));
      end
      S_JRK: begin
        op_a = MUL_A_W'(accel_q) - MUL_A_W'(last_q);
        op_d = div_w;
      end
      default: ;
    endcase
  end

  // result arithmetic
  always_comb begin
    tgt22   = 22'(target_q);
    prv22   = 22'(prev_q);
    step22  = $signed({1'b0, res[20:0]});
    diff22  = (target_q >= prev_q) ? (tgt22 - prv22) : (prv22 - tgt22);
    mn22    = (diff22 < step22) ? diff22 : step22;
    md34    = $signed({{(MUL_A_W-21){1'b0}}, res[20:0]});
    lo34    = MUL_A_W'(last_q) - md34;
    hi34    = MUL_A_W'(last_q) + md34;
    acc34   = MUL_A_W'(accel_q);
    mnv34   = (hi34 < acc34) ? hi34 : acc34;
    x56     = PROD_W'(prev_q) + res;
    x0      = (x56 < 0) ? '0 : x56;
    prof56  = PROD_W'(prof_q);
    sat_res = sat32(res);
  end

  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    second_d    = second_q;
    applied_d   = applied_q;
    jv_d        = jv_q;
    have_last_d = have_last_q;
    last_d      = last_q;
    cmd_d       = cmd_q;
    prev_d      = prev_q;
    prof_d      = prof_q;
    target_d    = target_q;
    capped_d    = capped_q;
    dt_d        = dt_q;
    accel_d     = accel_q;
    jerk_d      = jerk_q;
    lim_d       = lim_q;
    if (issue_q && state_q != S_IDLE && state_q != S_OUT) begin
      issue_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = command_speed_i;
          prev_d    = prev_in;
          prof_d    = prof_in;
          target_d  = target_in;
          dt_d      = tick_length_i;
          capped_d  = command_speed_i;
          accel_d   = '0;
          jerk_d    = '0;
          jv_d      = 1'b0;
          applied_d = 1'b0;
          second_d  = 1'b0;
          if (!cfg.enable || !profile_present_i) begin
            have_last_d = 1'b0;
            last_d      = '0;
            state_d     = S_OUT;
          end else if (!profile_valid_i) begin
            state_d = S_OUT;
          end else begin
            applied_d = 1'b1;
            jv_d      = have_last_q;
            capped_d  = target_in;
            issue_d   = 1'b1;
            state_d   = (tick_length_i > DT_W'(1)) ? S_STEP : S_ACC;
          end
        end
      end
      S_STEP: begin
        if (md_st.done) begin
          capped_d = (target_q >= prev_q) ? SPEED_W'(prv22 + mn22) : SPEED_W'(prv22 - mn22);
          issue_d  = 1'b1;
          state_d  = S_ACC;
        end
      end
      S_ACC: begin
        if (md_st.done) begin
          accel_d = sat_res;
          issue_d = 1'b1;
          if (!second_q && jerk_on) begin
            if (long_tick) begin
              state_d = S_MD;
            end else begin
              lim_d   = MUL_A_W'(sat_res);
              state_d = S_LIM;
            end
          end else if (have_last_q) begin
            state_d = S_JRK;
          end else begin
            last_d      = sat_res;
            have_last_d = 1'b1;
            state_d     = S_OUT;
          end
        end
      end
      S_MD: begin
        if (md_st.done) begin
          lim_d   = (mnv34 > lo34) ? mnv34 : lo34;
          issue_d = 1'b1;
          state_d = S_LIM;
        end
      end
      S_LIM: begin
        if (md_st.done) begin
          capped_d = (x0 > prof56) ? prof_q : x0[SPEED_W-1:0];
          second_d = 1'b1;
          issue_d  = 1'b1;
          state_d  = S_ACC;
        end
      end
      S_JRK: begin
        if (md_st.done) begin
          jerk_d      = sat_res;
          last_d      = accel_q;
          have_last_d = 1'b1;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= 1'b0;
      second_q    <= 1'b0;
      applied_q   <= 1'b0;
      jv_q        <= 1'b0;
      have_last_q <= 1'b0;
      last_q      <= '0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      second_q    <= second_d;
      applied_q   <= applied_d;
      jv_q        <= jv_d;
      have_last_q <= have_last_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    prev_q   <= prev_d;
    prof_q   <= prof_d;
    target_q <= target_d;
    capped_q <= capped_d;
    dt_q     <= dt_d;
    accel_q  <= accel_d;
    jerk_q   <= jerk_d;
    lim_q    <= lim_d;
  end

  assign in_ready_o           = state_q == S_IDLE;
  assign out_valid_o          = state_q == S_OUT;
  assign capped_speed_o       = capped_q;
  assign applied_o            = applied_q;
  assign active_o             = applied_q && ((cmd_q != capped_q) || (cmd_q != target_q));
  assign profile_speed_used_o = applied_q ? prof_q : '0;
  assign implied_accel_o      = accel_q;
  assign jerk_rate_o          = jerk_q;
  assign jerk_valid_o         = jv_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("ready while a result word is pending");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after accepting a word");
  a_jv_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && jerk_valid_o) |-> applied_o)
    else $error("jerk flagged valid on a pass-through word");
  a_md_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !md_st.busy)
    else $error("muldiv busy while sequencer idle");

endmodule

/* src/jlsc_cfg_regs.sv */
// Configuration register file with limit fallback resolution.
// Depends on jlsc_pkg.
`timescale 1ns / 1ps
module jlsc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jlsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jlsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output jlsc_pkg::cfg_t                 cfg_o
);
  import jlsc_pkg::*;

  logic              enable_q;
  logic [LIM_W-1:0]  accel_set_q, decel_set_q, path_accel_q, path_decel_q, veh_accel_q;
  logic [JERK_W-1:0] jerk_set_q;
  logic [LIM_W-1:0]  alim, dlim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      accel_set_q  <= '0;
      decel_set_q  <= '0;
      jerk_set_q   <= '0;
      path_accel_q <= '0;
      path_decel_q <= '0;
      veh_accel_q  <= VEH_ACCEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENABLE:     enable_q     <= cfg_data_i[0];
        CFG_ACCEL_LIM:  accel_set_q  <= cfg_data_i[LIM_W-1:0];
        CFG_DECEL_LIM:  decel_set_q  <= cfg_data_i[LIM_W-1:0];
        CFG_JERK_LIM:   jerk_set_q   <= cfg_data_i[JERK_W-1:0];
        CFG_PATH_ACCEL: path_accel_q <= cfg_data_i[LIM_W-1:0];
        CFG_PATH_DECEL: path_decel_q <= cfg_data_i[LIM_W-1:0];
        CFG_VEH_ACCEL:  veh_accel_q  <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (accel_set_q != '0) begin
      alim = accel_set_q;
    end else if (path_accel_q != '0) begin
      alim = path_accel_q;
    end else if (veh_accel_q != '0) begin
      alim = veh_accel_q;
    end else begin
      alim = LIM_W'(1);
    end
    if (decel_set_q != '0) begin
      dlim = decel_set_q;
    end else if (path_decel_q != '0) begin
      dlim = path_decel_q;
    end else begin
      dlim = alim;
    end
  end

  assign cfg_o.enable    = enable_q;
  assign cfg_o.accel_lim = alim;
  assign cfg_o.decel_lim = dlim;
  assign cfg_o.jerk_lim  = jerk_set_q;

endmodule

/* src/jlsc_muldiv.sv */
// Shared multiply-then-divide unit: q = trunc(a * b / d), one quotient bit per cycle.
// Depends on jlsc_pkg. Operands must hold from start until done.
`timescale 1ns / 1ps
module jlsc_muldiv (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [jlsc_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [jlsc_pkg::MUL_B_W-1:0] b_i,
  input  logic        [jlsc_pkg::DIV_D_W-1:0] d_i,
  output jlsc_pkg::md_status_t               status_o,
  output logic signed [jlsc_pkg::PROD_W-1:0]  q_o
);
  import jlsc_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_MUL   = 3'd1;
  localparam logic [2:0] P_SETUP = 3'd2;
  localparam logic [2:0] P_DIV   = 3'd3;
  localparam logic [2:0] P_DONE  = 3'd4;

  logic [2:0]               phase_q, phase_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     neg_q, neg_d;
  logic [QUO_W-1:0]         n_q, n_d;
  logic [DIV_D_W-1:0]       r_q, r_d;

  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        mag;
  logic [DIV_D_W:0]         rs, rn;
  logic                     ge;

  assign prod = a_i * b_i;
  assign mag  = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign rs   = {r_q, n_q[QUO_W-1]};
  assign ge   = rs >= {1'b0, d_i};
  assign rn   = ge ? (rs - {1'b0, d_i}) : rs;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    neg_d   = neg_q;
    n_d     = n_q;
    r_d     = r_q;
    case (phase_q)
      P_IDLE: begin
        if (start_i) begin
          phase_d = P_MUL;
        end
      end
      P_MUL: begin
        prod_d  = prod;
        phase_d = P_SETUP;
      end
      P_SETUP: begin
        neg_d   = prod_q[PROD_W-1];
        n_d     = mag[QUO_W-1:0];
        r_d     = '0;
        cnt_d   = CNT_W'(QUO_W);
        phase_d = P_DIV;
      end
      P_DIV: begin
        r_d   = rn[DIV_D_W-1:0];
        n_d   = {n_q[QUO_W-2:0], ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          phase_d = P_DONE;
        end
      end
      P_DONE: begin
        phase_d = P_IDLE;
      end
      default: phase_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg_d;
    n_q    <= n_d;
    r_q    <= r_d;
  end

  assign q_o = neg_q ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
  assign status_o.busy = phase_q != P_IDLE;
  assign status_o.done = phase_q == P_DONE;

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == P_DIV) |-> (cnt_q != '0))
    else $error("divider running with zero count");
  a_setup_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == P_MUL) |=> (phase_q == P_SETUP))
    else $error("multiply not followed by setup");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.done |=> !status_o.done)
    else $error("done held longer than one cycle");

endmodule

/* bench/tb_jerk_limited_speed_cap.sv */
// Self-checking bench for jerk_limited_speed_cap: directed table, then random phases with
// random settings, handshake gaps on both sides and an in-bench model of the speed cap.
// Depends on jlsc_pkg and the jerk_limited_speed_cap RTL.
`timescale 1ns / 1ps
module tb_jerk_limited_speed_cap;
  import jlsc_pkg::*;

  localparam longint US_PER_S = 1000000;
  localparam longint ACC_MAX = 64'sd2147483647;
  localparam longint ACC_MIN = -64'sd2147483648;
  localparam int STALL_LIMIT = 8000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum {SU_KEEP, SU_ENABLE, SU_JERK, SU_PATH, SU_VEH, SU_MAX, SU_UNIT, SU_OFF} setup_e;

  typedef struct {
    logic signed [SPEED_W-1:0] cmd;
    logic signed [SPEED_W-1:0] prev;
    logic        [DT_W-1:0]    tick;
    logic                      present;
    logic                      pvalid;
    logic signed [SPEED_W-1:0] here;
    logic signed [SPEED_W-1:0] ahead;
  } tick_word_t;

  typedef struct {
    logic signed [SPEED_W-1:0] capped;
    logic                      applied;
    logic                      active;
    logic signed [SPEED_W-1:0] prof_used;
    logic signed [ACC_W-1:0]   accel;
    logic signed [ACC_W-1:0]   jerk;
    logic                      jerk_valid;
  } cap_result_t;

  typedef struct {
    setup_e setup;
    int     cmd;
    int     prev;
    int     tick;
    bit     present;
    bit     pvalid;
    int     here;
    int     ahead;
    bit     has_exp;
    int     exp_capped;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic signed [SPEED_W-1:0] cmd_spd = '0;
  logic signed [SPEED_W-1:0] prev_spd = '0;
  logic [DT_W-1:0] tick_len = '0;
  logic prof_present = 1'b0;
  logic prof_valid = 1'b0;
  logic signed [SPEED_W-1:0] prof_here = '0;
  logic signed [SPEED_W-1:0] prof_ahead = '0;

  logic in_ready;
  logic out_valid;
  logic signed [SPEED_W-1:0] capped_speed;
  logic applied;
  logic active;
  logic signed [SPEED_W-1:0] profile_speed_used;
  logic signed [ACC_W-1:0] implied_accel;
  logic signed [ACC_W-1:0] jerk_rate;
  logic jerk_valid;

  // model settings and stored acceleration
  logic              cap_on = 1'b0;
  logic [LIM_W-1:0]  own_accel = '0;
  logic [LIM_W-1:0]  own_decel = '0;
  logic [JERK_W-1:0] jerk_cap = '0;
  logic [LIM_W-1:0]  path_accel = '0;
  logic [LIM_W-1:0]  path_decel = '0;
  logic [LIM_W-1:0]  veh_accel = VEH_ACCEL_RST;
  logic              have_prev_accel = 1'b0;
  logic signed [ACC_W-1:0] prev_accel = '0;

  cap_result_t capped_q[$];
  logic signed [SPEED_W-1:0] fb_speed = '0;
  bit calm = 1'b0;
  int errors = 0;
  int idle_cnt = 0;

  dir_row_t dir_tab [24] = '{
    '{SU_KEEP,    524287,       0,   10000, 1, 1,  100000,       0, 1,  524287},
    '{SU_KEEP,   -524288, -524288,       0, 1, 1,       0,       0, 1, -524288},
    '{SU_ENABLE,   12345,       0,   10000, 0, 1,   40960,       0, 1,   12345},
    '{SU_KEEP,     20000,       0,   10000, 1, 0,   40960,       0, 1,   20000},
    '{SU_KEEP,     40960,       0,   10000, 1, 1,   81920,       0, 0,       0},
    '{SU_KEEP,     40960,      40,   10000, 1, 1,   81920,       0, 0,       0},
    '{SU_KEEP,     30000,     100,   10000, 1, 1,       0,   20480, 0,       0},
    '{SU_KEEP,     30000,     100,   10000, 1, 1,   -4096,   -8192, 0,       0},
    '{SU_KEEP,     30000,     100,       0, 1, 1,   81920,       0, 0,       0},
    '{SU_KEEP,     30000,     100,       1, 1, 1,   81920,       0, 0,       0},
    '{SU_KEEP,    524287, -524288, 1048575, 1, 1,  524287,  524287, 0,       0},
    '{SU_JERK,    100000,       0,   20000, 1, 1,  200000,       0, 0,       0},
    '{SU_KEEP,    100000,     160,   20000, 1, 1,  200000,       0, 0,       0},
    '{SU_KEEP,     50000,    4096,    5000, 1, 1,  -40960,  -81920, 0,       0},
    '{SU_KEEP,     50000,       0,       0, 1, 1,   81920,       0, 0,       0},
    '{SU_KEEP,         0,  400000,  100000, 1, 1,  500000,       0, 0,       0},
    '{SU_PATH,    200000,    1000,   50000, 1, 1,  300000,       0, 0,       0},
    '{SU_KEEP,         0,  200000,   50000, 1, 1,  300000,       0, 0,       0},
    '{SU_VEH,     200000,    1000,   50000, 1, 1,  300000,       0, 0,       0},
    '{SU_KEEP,         0,  200000,   50000, 1, 1,  300000,       0, 0,       0},
    '{SU_MAX,     524287, -524288, 1000000, 1, 1,  524287, -524288, 0,       0},
    '{SU_KEEP,   -524288,  524287, 1000000, 1, 1,  524287,  524287, 0,       0},
    '{SU_UNIT,    100000,       0, 1000000, 1, 1,  200000,       0, 0,       0},
    '{SU_OFF,        777,       0,   10000, 1, 1,  200000,       0, 1,     777}
  };

  jerk_limited_speed_cap dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .command_speed_i       (cmd_spd),
    .previous_speed_i      (prev_spd),
    .tick_length_i         (tick_len),
    .profile_present_i     (prof_present),
    .profile_valid_i       (prof_valid),
    .profile_speed_here_i  (prof_here),
    .profile_speed_ahead_i (prof_ahead),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .capped_speed_o        (capped_speed),
    .applied_o             (applied),
    .active_o              (active),
    .profile_speed_used_o  (profile_speed_used),
    .implied_accel_o       (implied_accel),
    .jerk_rate_o           (jerk_rate),
    .jerk_valid_o          (jerk_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip32(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  function automatic logic signed [SPEED_W-1:0] clamp20(input int v);
    if (v > 524287) return SPEED_W'(524287);
    if (v < -524288) return SPEED_W'(-524288);
    return SPEED_W'(v);
  endfunction

  function automatic cap_result_t predict_cap(input tick_word_t w);
    longint cmd, prev, dt, prof, target, capped, accel, jerk, div_dt, alim, dlim, md, lim;
    cap_result_t r;
    cmd = longint'(w.cmd);
    prev = longint'(w.prev);
    dt = longint'(w.tick);
    r.capped = w.cmd;
    r.applied = 1'b0;
    r.active = 1'b0;
    r.prof_used = '0;
    r.accel = '0;
    r.jerk = '0;
    r.jerk_valid = 1'b0;
    if (!cap_on || !w.present) begin
      have_prev_accel = 1'b0;
      prev_accel = '0;
      return r;
    end
    if (!w.pvalid) return r;

    prof = longint'(w.here);
    if (prof <= 0 && longint'(w.ahead) > prof) prof = longint'(w.ahead);
    if (prev < 0) prev = 0;
    target = (cmd < prof) ? cmd : prof;
    if (target < 0) target = 0;

    if (own_accel != 0) alim = longint'(own_accel);
    else if (path_accel != 0) alim = longint'(path_accel);
    else if (veh_accel != 0) alim = longint'(veh_accel);
    else alim = 1;
    if (own_decel != 0) dlim = longint'(own_decel);
    else if (path_decel != 0) dlim = longint'(path_decel);
    else dlim = alim;

    capped = target;
    if (dt > 1) begin
      if (target >= prev) begin
        md = alim * dt / US_PER_S;
        capped = (target - prev < md) ? target : prev + md;
      end else begin
        md = dlim * dt / US_PER_S;
        capped = (prev - target < md) ? target : prev - md;
      end
    end
    div_dt = (dt > 1) ? dt : 1;
    accel = clip32((capped - prev) * US_PER_S / div_dt);

    if (jerk_cap != 0 && have_prev_accel) begin
      lim = accel;
      if (dt > 1) begin
        md = longint'(jerk_cap) * dt / US_PER_S;
        if (lim > prev_accel + md) lim = prev_accel + md;
        if (lim < prev_accel - md) lim = prev_accel - md;
      end
      capped = prev + lim * dt / US_PER_S;
      if (capped < 0) capped = 0;
      if (capped > prof) capped = prof;
      accel = clip32((capped - prev) * US_PER_S / div_dt);
    end
    jerk = 0;
    if (have_prev_accel) jerk = clip32((accel - prev_accel) * US_PER_S / div_dt);
    r.jerk_valid = have_prev_accel;
    prev_accel = ACC_W'(accel);
    have_prev_accel = 1'b1;

    r.capped = SPEED_W'(capped);
    r.applied = 1'b1;
    r.active = (cmd != capped) || (cmd != target);
    r.prof_used = SPEED_W'(prof);
    r.accel = ACC_W'(accel);
    r.jerk = ACC_W'(jerk);
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_limit();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(256, 65536));
    endcase
  endfunction

  // mostly a plausible tick following the last capped speed, some raw noise
  function automatic tick_word_t rand_word();
    tick_word_t w;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      w.cmd = SPEED_W'($urandom);
      w.prev = SPEED_W'($urandom);
      w.tick = DT_W'($urandom);
      w.present = 1'($urandom);
      w.pvalid = 1'($urandom);
      w.here = SPEED_W'($urandom);
      w.ahead = SPEED_W'($urandom);
      return w;
    end
    w.present = ($urandom_range(0, 19) != 0);
    w.pvalid = ($urandom_range(0, 19) != 0);
    w.prev = (sel == 1) ? clamp20(int'(fb_speed) + int'($urandom_range(0, 8000)) - 4000)
                        : fb_speed;
    case ($urandom_range(0, 5))
      0: w.here = clamp20(-int'($urandom_range(0, 50000)));
      1: w.here = SPEED_W'($urandom_range(0, 4000));
      default: w.here = SPEED_W'($urandom_range(20000, 400000));
    endcase
    w.ahead = clamp20(int'($urandom_range(0, 400000)) - 50000);
    case ($urandom_range(0, 3))
      0: w.cmd = clamp20(int'(w.here) + int'($urandom_range(0, 100000)) - 50000);
      1: w.cmd = clamp20(-int'($urandom_range(0, 100000)));
      default: w.cmd = SPEED_W'($urandom_range(0, 450000));
    endcase
    case ($urandom_range(0, 9))
      0: w.tick = DT_W'($urandom_range(0, 1));
      1: w.tick = DT_W'($urandom);
      2: w.tick = DT_W'($urandom_range(100000, 1000000));
      default: w.tick = DT_W'($urandom_range(1000, 50000));
    endcase
    return w;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_ENABLE:     cap_on = data[0];
      CFG_ACCEL_LIM:  own_accel = data[LIM_W-1:0];
      CFG_DECEL_LIM:  own_decel = data[LIM_W-1:0];
      CFG_JERK_LIM:   jerk_cap = data[JERK_W-1:0];
      CFG_PATH_ACCEL: path_accel = data[LIM_W-1:0];
      CFG_PATH_DECEL: path_decel = data[LIM_W-1:0];
      CFG_VEH_ACCEL:  veh_accel = data[LIM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setup(input setup_e s);
    case (s)
      SU_ENABLE: cfg_write(CFG_ENABLE, 20'd1);
      SU_JERK: begin
        cfg_write(CFG_ACCEL_LIM, 20'd8192);
        cfg_write(CFG_DECEL_LIM, 20'd16384);
        cfg_write(CFG_JERK_LIM, 20'd4096);
      end
      SU_PATH: begin
        cfg_write(CFG_ACCEL_LIM, '0);
        cfg_write(CFG_DECEL_LIM, '0);
        cfg_write(CFG_JERK_LIM, '0);
        cfg_write(CFG_PATH_ACCEL, 20'd2048);
        cfg_write(CFG_PATH_DECEL, 20'd1024);
      end
      SU_VEH: begin
        cfg_write(CFG_PATH_ACCEL, '0);
        cfg_write(CFG_PATH_DECEL, '0);
        cfg_write(CFG_VEH_ACCEL, 20'd8192);
      end
      SU_MAX: begin
        cfg_write(CFG_ENABLE, '1);
        cfg_write(CFG_ACCEL_LIM, '1);
        cfg_write(CFG_DECEL_LIM, '1);
        cfg_write(CFG_JERK_LIM, '1);
        cfg_write(CFG_PATH_ACCEL, '1);
        cfg_write(CFG_PATH_DECEL, '1);
        cfg_write(CFG_VEH_ACCEL, '1);
      end
      SU_UNIT: begin
        cfg_write(CFG_ACCEL_LIM, '0);
        cfg_write(CFG_DECEL_LIM, '0);
        cfg_write(CFG_JERK_LIM, '0);
        cfg_write(CFG_PATH_ACCEL, '0);
        cfg_write(CFG_PATH_DECEL, '0);
        cfg_write(CFG_VEH_ACCEL, '0);
      end
      SU_OFF: cfg_write(CFG_ENABLE, '0);
      default: ;
    endcase
  endtask

  task automatic rand_setting();
    logic [CFG_DATA_W-1:0] en_word;
    en_word = CFG_DATA_W'($urandom);
    en_word[0] = ($urandom_range(0, 7) != 0);
    cfg_write(CFG_ENABLE, en_word);
    cfg_write(CFG_ACCEL_LIM, rand_limit());
    cfg_write(CFG_DECEL_LIM, rand_limit());
    cfg_write(CFG_JERK_LIM, rand_limit());
    cfg_write(CFG_PATH_ACCEL, rand_limit());
    cfg_write(CFG_PATH_DECEL, rand_limit());
    cfg_write(CFG_VEH_ACCEL, rand_limit());
    if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
  endtask

  // holds valid from the drive until the accepting edge, then returns
  task automatic send_word(input tick_word_t w, input bit typed, input cap_result_t typed_res);
    int gap;
    cap_result_t r;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_spd <= w.cmd;
    prev_spd <= w.prev;
    tick_len <= w.tick;
    prof_present <= w.present;
    prof_valid <= w.pvalid;
    prof_here <= w.here;
    prof_ahead <= w.ahead;
    do @(posedge clk); while (!in_ready);
    r = predict_cap(w);
    capped_q.push_back(typed ? typed_res : r);
    if (r.applied) fb_speed = r.capped;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (capped_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input longint e, input longint a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, e, a);
    end
  endtask

  initial begin
    cap_result_t exp_r;
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (capped_q.size() == 0) begin
        errors++;
        $display("%0t: word with no expectation, capped_speed %0d", $time, capped_speed);
      end else begin
        exp_r = capped_q.pop_front();
        check_field("capped_speed", longint'(exp_r.capped), longint'(capped_speed));
        check_field("applied", longint'(exp_r.applied), longint'(applied));
        check_field("active", longint'(exp_r.active), longint'(active));
        check_field("profile_speed_used", longint'(exp_r.prof_used),
                    longint'(profile_speed_used));
        check_field("implied_accel", longint'(exp_r.accel), longint'(implied_accel));
        check_field("jerk_rate", longint'(exp_r.jerk), longint'(jerk_rate));
        check_field("jerk_valid", longint'(exp_r.jerk_valid), longint'(jerk_valid));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    dir_row_t row;
    tick_word_t w;
    cap_result_t t;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.setup != SU_KEEP) begin
        drain();
        apply_setup(row.setup);
      end
      w.cmd = SPEED_W'(row.cmd);
      w.prev = SPEED_W'(row.prev);
      w.tick = DT_W'(row.tick);
      w.present = row.present;
      w.pvalid = row.pvalid;
      w.here = SPEED_W'(row.here);
      w.ahead = SPEED_W'(row.ahead);
      t.capped = SPEED_W'(row.exp_capped);
      t.applied = 1'b0;
      t.active = 1'b0;
      t.prof_used = '0;
      t.accel = '0;
      t.jerk = '0;
      t.jerk_valid = 1'b0;
      send_word(w, row.has_exp, t);
    end

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      rand_setting();
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 100; i++) begin
        if (i == 50 && (ph == 0 || $urandom_range(0, 2) == 0)) drain();
        send_word(rand_word(), 1'b0, t);
      end
    end

    drain();
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
